// ===== hw/rtl/psu_pkg.sv =====
`default_nettype none

package psu_pkg;

    localparam int ElemTypeW = 3;
    localparam int CfgIndexW = 3;
    localparam int WordW = 32;

    typedef enum logic [ElemTypeW-1:0] {
        ET_INT8    = 3'd0,
        ET_UINT8   = 3'd1,
        ET_INT16   = 3'd2,
        ET_INT32   = 3'd3,
        ET_FLOAT32 = 3'd4,
        ET_FLOAT64 = 3'd5
    } elem_type_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_ELEMENT_TYPE = 3'd0,
        REG_SCALE        = 3'd1,
        REG_OFFSET       = 3'd2,
        REG_FILL         = 3'd3,
        REG_MISSING      = 3'd4
    } cfg_reg_t;

    localparam logic [31:0] CanonNan    = 32'h7FC0_0000;
    localparam logic [30:0] InfMag      = 31'h7F80_0000;
    localparam logic [31:0] ResetScale  = 32'h3F80_0000;
    localparam logic [31:0] ResetOffset = 32'h0000_0000;
    localparam logic [31:0] ResetFill   = 32'h7CF0_0000;

    function automatic logic is_nan(logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(logic [31:0] f);
        return f[30:0] == 31'd0;
    endfunction

    // Leading zero counts; an all-zero word yields the full width.
    function automatic logic [5:0] lzc32(logic [31:0] v);
        logic [5:0] c;
        c = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                c = 6'(31 - i);
            end
        end
        return c;
    endfunction

    function automatic logic [5:0] lzc48(logic [47:0] v);
        logic [5:0] c;
        c = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                c = 6'(47 - i);
            end
        end
        return c;
    endfunction

    function automatic logic [5:0] lzc49(logic [48:0] v);
        logic [5:0] c;
        c = 6'd49;
        for (int i = 0; i < 49; i++) begin
            if (v[i]) begin
                c = 6'(48 - i);
            end
        end
        return c;
    endfunction

    // Rounds a significand whose leading one sits in bit 47 to a binary32
    // magnitude with biased exponent e, nearest even, with overflow to
    // infinity and gradual underflow into subnormals.
    function automatic logic [30:0] round_mag(logic signed [11:0] e, logic [47:0] n,
                                              logic st_in);
        logic [63:0] w;
        logic [63:0] q;
        logic [63:0] mask;
        logic        g;
        logic        st;
        logic        up;
        logic [31:0] base;
        logic [31:0] sum;
        int          sh;
        if (e >= 12'sd255) begin
            return InfMag;
        end
        if (e >= 12'sd1) begin
            sh = 24;
        end else begin
            sh = 25 - int'(e);
            if (sh > 60) begin
                sh = 60;
            end
        end
        w    = {16'd0, n};
        q    = w >> sh;
        g    = w[sh-1];
        mask = (64'd1 << (sh - 1)) - 64'd1;
        st   = (|(w & mask)) | st_in;
        up   = g & (st | q[0]);
        base = (e >= 12'sd1) ? {1'b0, e[7:0] - 8'd1, 23'd0} : 32'd0;
        sum  = base + q[31:0] + {31'd0, up};
        return sum[30:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/packed_sample_unpack_to_float_top.sv =====
// Throughput: one element per cycle; each stage holds while its successor is full
// and stalled, and an empty stage takes new data even when the output waits.
// Stages: convert, fill compare and significand product, product rounding,
// offset alignment and add, sum normalisation and rounding.
// Reset clears all valid bits and loads the configuration defaults.
`default_nettype none

module packed_sample_unpack_to_float_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [psu_pkg::CfgIndexW-1:0]  cfg_index,
    input  wire logic [psu_pkg::WordW-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [63:0]                    element_bits,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [31:0]                         value_bits,
    output logic                                is_missing
);
    import psu_pkg::*;

    logic [ElemTypeW-1:0] elem_type_reg;
    logic [31:0]          scale_reg;
    logic [31:0]          offset_reg;
    logic [31:0]          fill_reg;
    logic [31:0]          missing_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            elem_type_reg <= ET_FLOAT32;
            scale_reg     <= ResetScale;
            offset_reg    <= ResetOffset;
            fill_reg      <= ResetFill;
            missing_reg   <= ResetFill;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ELEMENT_TYPE: elem_type_reg <= cfg_data[ElemTypeW-1:0];
                REG_SCALE:        scale_reg     <= cfg_data;
                REG_OFFSET:       offset_reg    <= cfg_data;
                REG_FILL:         fill_reg      <= cfg_data;
                REG_MISSING:      missing_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Stage valid bits and per-stage load enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ---------------- Stage 1: element to binary32 ----------------
    logic [31:0] s1_val_reg, s1_val_next;

    always_comb begin
        logic signed [31:0] iv;
        logic [31:0]        mag;
        logic [5:0]         lz;
        logic [31:0]        nrm;
        logic [10:0]        e64;
        logic [51:0]        m64;
        logic [52:0]        sig;
        logic               is_int;
        iv     = 32'sd0;
        is_int = 1'b1;
        s1_val_next = CanonNan;
        e64 = element_bits[62:52];
        m64 = element_bits[51:0];
        sig = {1'b1, m64};
        unique case (elem_type_reg)
            ET_INT8:    iv = {{24{element_bits[7]}}, element_bits[7:0]};
            ET_UINT8:   iv = {24'd0, element_bits[7:0]};
            ET_INT16:   iv = {{16{element_bits[15]}}, element_bits[15:0]};
            ET_INT32:   iv = element_bits[31:0];
            default:    is_int = 1'b0;
        endcase
        mag = iv[31] ? (32'd0 - iv) : iv;
        lz  = lzc32(mag);
        nrm = mag << lz;
        if (is_int) begin
            if (mag == 32'd0) begin
                s1_val_next = 32'd0;
            end else begin
                s1_val_next = {iv[31],
                               round_mag(12'sd158 - 12'(lz), {nrm, 16'd0}, 1'b0)};
            end
        end else if (elem_type_reg == ET_FLOAT32) begin
            s1_val_next = element_bits[31:0];
        end else if (elem_type_reg == ET_FLOAT64) begin
            if (e64 == 11'h7FF) begin
                s1_val_next = (m64 != 52'd0) ? CanonNan : {element_bits[63], InfMag};
            end else if (e64 == 11'd0) begin
                s1_val_next = {element_bits[63], 31'd0};
            end else begin
                s1_val_next = {element_bits[63],
                               round_mag(12'({1'b0, e64}) - 12'sd896, sig[52:5],
                                         |sig[4:0])};
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en1) s1_val_reg <= s1_val_next;
    end

    // ---------------- Stage 2: fill compare, significand product ----------------
    logic               s2_miss_reg, s2_miss_next;
    logic               s2_spec_reg, s2_spec_next;
    logic [31:0]        s2_spec_val_reg, s2_spec_val_next;
    logic               s2_sign_reg, s2_sign_next;
    logic signed [11:0] s2_e_reg, s2_e_next;
    logic [47:0]        s2_p_reg, s2_p_next;

    always_comb begin
        logic [31:0] a;
        logic [31:0] b;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [7:0]  ea;
        logic [7:0]  eb;
        a  = s1_val_reg;
        b  = scale_reg;
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        s2_miss_next = !is_nan(a) &&
            ((!is_nan(fill_reg) && (a == fill_reg || (is_zero(a) && is_zero(fill_reg)))) ||
             (!is_nan(missing_reg) &&
              (a == missing_reg || (is_zero(a) && is_zero(missing_reg)))));
        s2_sign_next = a[31] ^ b[31];
        s2_e_next    = 12'(ea) + 12'(eb) - 12'sd126;
        s2_p_next    = ma * mb;
        s2_spec_next = 1'b1;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) ||
            (is_inf(b) && is_zero(a))) begin
            s2_spec_val_next = CanonNan;
        end else if (is_inf(a) || is_inf(b)) begin
            s2_spec_val_next = {s2_sign_next, InfMag};
        end else if (is_zero(a) || is_zero(b)) begin
            s2_spec_val_next = {s2_sign_next, 31'd0};
        end else begin
            s2_spec_next     = 1'b0;
            s2_spec_val_next = CanonNan;
        end
    end

    always_ff @(posedge clk) begin
        if (en2) begin
            s2_miss_reg     <= s2_miss_next;
            s2_spec_reg     <= s2_spec_next;
            s2_spec_val_reg <= s2_spec_val_next;
            s2_sign_reg     <= s2_sign_next;
            s2_e_reg        <= s2_e_next;
            s2_p_reg        <= s2_p_next;
        end
    end

    // ---------------- Stage 3: product normalisation and rounding ----------------
    logic        s3_miss_reg;
    logic [31:0] s3_prod_reg, s3_prod_next;

    always_comb begin
        logic [5:0]  lz;
        logic [47:0] nrm;
        lz  = lzc48(s2_p_reg);
        nrm = s2_p_reg << lz;
        if (s2_spec_reg) begin
            s3_prod_next = s2_spec_val_reg;
        end else begin
            s3_prod_next = {s2_sign_reg, round_mag(s2_e_reg - 12'(lz), nrm, 1'b0)};
        end
    end

    always_ff @(posedge clk) begin
        if (en3) begin
            s3_miss_reg <= s2_miss_reg;
            s3_prod_reg <= s3_prod_next;
        end
    end

    // ---------------- Stage 4: offset alignment and add ----------------
    logic               s4_miss_reg;
    logic               s4_spec_reg, s4_spec_next;
    logic [31:0]        s4_spec_val_reg, s4_spec_val_next;
    logic               s4_sign_reg, s4_sign_next;
    logic               s4_zsign_reg, s4_zsign_next;
    logic signed [11:0] s4_e_reg, s4_e_next;
    logic [48:0]        s4_s_reg, s4_s_next;

    always_comb begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [48:0] am;
        logic [48:0] bm;
        logic [48:0] bs;
        logic        st;
        a = s3_prod_reg;
        b = offset_reg;
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        am = {1'b0, x[30:23] != 8'd0, x[22:0], 24'd0};
        bm = {1'b0, y[30:23] != 8'd0, y[22:0], 24'd0};
        if (d > 8'd48) begin
            bs = 49'd0;
            st = |bm;
        end else begin
            bs = bm >> d;
            st = |(bm & ((49'd1 << d) - 49'd1));
        end
        bs[0] = bs[0] | st;
        s4_s_next     = (x[31] == y[31]) ? (am + bs) : (am - bs);
        s4_sign_next  = x[31];
        s4_zsign_next = a[31] & b[31];
        s4_e_next     = 12'(ex) + 12'sd1;
        s4_spec_next  = 1'b1;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
            s4_spec_val_next = CanonNan;
        end else if (is_inf(a)) begin
            s4_spec_val_next = a;
        end else if (is_inf(b)) begin
            s4_spec_val_next = b;
        end else begin
            s4_spec_next     = 1'b0;
            s4_spec_val_next = CanonNan;
        end
    end

    always_ff @(posedge clk) begin
        if (en4) begin
            s4_miss_reg     <= s3_miss_reg;
            s4_spec_reg     <= s4_spec_next;
            s4_spec_val_reg <= s4_spec_val_next;
            s4_sign_reg     <= s4_sign_next;
            s4_zsign_reg    <= s4_zsign_next;
            s4_e_reg        <= s4_e_next;
            s4_s_reg        <= s4_s_next;
        end
    end

    // ---------------- Stage 5: sum normalisation, rounding, output ----------------
    logic [31:0] s5_val_reg, s5_val_next;
    logic        s5_miss_reg;

    always_comb begin
        logic [5:0]  lz;
        logic [48:0] nrm;
        lz  = lzc49(s4_s_reg);
        nrm = s4_s_reg << lz;
        if (s4_miss_reg || s4_spec_reg) begin
            s5_val_next = s4_miss_reg ? CanonNan : s4_spec_val_reg;
        end else if (s4_s_reg == 49'd0) begin
            // Exact cancellation gives +0 unless both operands were -0.
            s5_val_next = {s4_zsign_reg, 31'd0};
        end else begin
            s5_val_next = {s4_sign_reg,
                           round_mag(s4_e_reg - 12'(lz), nrm[48:1], nrm[0])};
        end
    end

    always_ff @(posedge clk) begin
        if (en5) begin
            s5_val_reg  <= s5_val_next;
            s5_miss_reg <= s4_miss_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign value_bits = s5_val_reg;
    assign is_missing = s5_miss_reg;

endmodule

`default_nettype wire
